>>> rtl/core/vpm_pkg.sv
// shared constants and types for the 2d view-projection matrix block
package vpm_pkg;

   // cordic rotation steps
   localparam int ANGLE_ITERATIONS = 24;

   // angle reduction
   localparam int MOD_STEPS   = 7;
   localparam int DIV45_STEPS = 5;
   localparam int D45_BITS    = 8;
   localparam int D45_W       = DIV45_STEPS * D45_BITS;
   localparam int Y_W         = 37;
   localparam int MAG_W       = 23;
   localparam int M0_W        = 25;
   localparam int CW          = 33;

   localparam logic [31:0]     DEG_360    = 32'd23592960;
   localparam logic [M0_W-1:0] DEG_360_M  = 25'd23592960;
   localparam logic [M0_W-1:0] DEG_270_M  = 25'd17694720;
   localparam logic [M0_W-1:0] DEG_180_M  = 25'd11796480;
   localparam logic [M0_W-1:0] DEG_90_M   = 25'd5898240;
   localparam logic [31:0]     TWO_PI_Q29 = 32'd3373259426;
   localparam logic [6:0]      DIV45      = 7'd45;
   localparam logic signed [CW-1:0] CORDIC_K_Q30 = 33'sd652032874;

   localparam logic [29:0] ATAN_Q30 [0:31] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
      30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
      30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
      30'd262143,    30'd131071,    30'd65535,     30'd32767,
      30'd16383,     30'd8191,      30'd4095,      30'd2047,
      30'd1023,      30'd511,       30'd255,       30'd127,
      30'd63,        30'd31,        30'd15,        30'd8,
      30'd4,         30'd2,         30'd1,         30'd0
   };

   // divider
   localparam int NUM_W   = 66;
   localparam int DEN_W   = 46;
   localparam int Q_BITS  = 33;
   localparam int HI_W    = NUM_W + 1 - Q_BITS;
   localparam int DIV_LAT = Q_BITS + 4;

   localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] w;
      logic signed [31:0] h;
   } cam_type;

   typedef struct packed {
      logic negm;
      logic flip;
   } fold_type;

endpackage

>>> rtl/core/vpm_div.sv
// pipelined signed divider, round to nearest, saturated to 32 bits
module vpm_div
   import vpm_pkg::*;
(
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [DEN_W-1:0] den,
   output logic signed [31:0]      quo,
   output logic                    sat
);

   logic [NUM_W-1:0] un_in, un_ff;
   logic [DEN_W-1:0] ud_in, ud_a_ff, ud_b_ff;
   logic             neg_in, neg_a_ff, neg_b_ff;
   logic [NUM_W:0]   nn_in, nn_ff;

   logic [DEN_W-1:0]  ud_st_ff  [0:Q_BITS];
   logic [DEN_W-1:0]  rem_st_ff [0:Q_BITS];
   logic [Q_BITS-1:0] lq_st_ff  [0:Q_BITS];
   logic              neg_st_ff [0:Q_BITS];
   logic              ovf_st_ff [0:Q_BITS];

   logic [HI_W-1:0]   hi;
   logic              ovf_c_in;
   logic [DEN_W-1:0]  rem_c_in;

   logic [Q_BITS-1:0]  qf;
   logic               big_neg, big_pos;
   logic signed [31:0] quo_in, quo_ff;
   logic               sat_in, sat_ff;

   // magnitudes and result sign
   always_comb begin
      un_in  = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
      ud_in  = den[DEN_W-1] ? (~den + DEN_W'(1)) : den;
      neg_in = num[NUM_W-1] ^ den[DEN_W-1];
   end

   // add half the divisor for rounding
   assign nn_in = (NUM_W+1)'(un_ff) + (NUM_W+1)'(ud_a_ff >> 1);

   // quotient too large for the remaining bits means saturation
   always_comb begin
      hi       = nn_ff[NUM_W:Q_BITS];
      ovf_c_in = {{(DEN_W-HI_W){1'b0}}, hi} >= ud_b_ff;
      rem_c_in = {{(DEN_W-HI_W){1'b0}}, hi};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         un_ff        <= un_in;
         ud_a_ff      <= ud_in;
         neg_a_ff     <= neg_in;
         nn_ff        <= nn_in;
         ud_b_ff      <= ud_a_ff;
         neg_b_ff     <= neg_a_ff;
         ud_st_ff[0]  <= ud_b_ff;
         rem_st_ff[0] <= rem_c_in;
         lq_st_ff[0]  <= nn_ff[Q_BITS-1:0];
         neg_st_ff[0] <= neg_b_ff;
         ovf_st_ff[0] <= ovf_c_in;
      end
   end

   // one quotient bit per stage, quotient shifts in as numerator shifts out
   for (genvar j = 1; j <= Q_BITS; j++) begin : g_step
      logic [DEN_W:0]    r2;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [Q_BITS-1:0] lq_in;

      always_comb begin
         r2     = {rem_st_ff[j-1], lq_st_ff[j-1][Q_BITS-1]};
         ge     = r2 >= {1'b0, ud_st_ff[j-1]};
         rem_in = ge ? DEN_W'(r2 - {1'b0, ud_st_ff[j-1]}) : r2[DEN_W-1:0];
         lq_in  = {lq_st_ff[j-1][Q_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ud_st_ff[j]  <= ud_st_ff[j-1];
            rem_st_ff[j] <= rem_in;
            lq_st_ff[j]  <= lq_in;
            neg_st_ff[j] <= neg_st_ff[j-1];
            ovf_st_ff[j] <= ovf_st_ff[j-1];
         end
      end
   end

   always_comb begin
      qf      = lq_st_ff[Q_BITS];
      big_pos = (|qf[Q_BITS-1:32]) | qf[31];
      big_neg = (|qf[Q_BITS-1:32]) | (qf[31] & (|qf[30:0]));
      if (neg_st_ff[Q_BITS]) begin
         sat_in = ovf_st_ff[Q_BITS] | big_neg;
         quo_in = sat_in ? Q_MIN : -$signed(qf[31:0]);
      end else begin
         sat_in = ovf_st_ff[Q_BITS] | big_pos;
         quo_in = sat_in ? Q_MAX : $signed(qf[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
         sat_ff <= sat_in;
      end
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule

>>> rtl/core/view_projection_matrix_2d.sv
// 2d orthographic camera to view-projection matrix, fully pipelined
//
// request channel: camera center, view size and rotation in degrees, all
// signed q16.16, moved on req_valid with req_stall low. result channel:
// the six variable entries of the 3x3 matrix in signed q16.16 plus the
// size error and saturation flags, moved on rsp_valid with rsp_stall low.
// one request enters per cycle and one result leaves per cycle unless
// rsp_stall holds the output. the pipeline holds seven angle
// reduction steps, a divide by 45 over five stages, one cordic stage per
// rotation step, and a 37 stage divider per entry, one bit per step stage.
// every stage moves together; when a result is held on the output by
// rsp_stall the whole pipeline freezes and req_stall goes high, so nothing
// is lost or repeated. reset clears the valid bits only; no results come
// out until new requests arrive. a zero width or height gives zero
// entries with size_error set.
module view_projection_matrix_2d
   import vpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_view_width,
   input  logic signed [31:0] req_view_height,
   input  logic signed [31:0] req_rotation_degrees,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_row0_col0,
   output logic signed [31:0] rsp_row0_col1,
   output logic signed [31:0] rsp_row0_col2,
   output logic signed [31:0] rsp_row1_col0,
   output logic signed [31:0] rsp_row1_col1,
   output logic signed [31:0] rsp_row1_col2,
   output logic               rsp_size_error,
   output logic               rsp_saturated
);

   localparam int PIPE_LAT = 1 + MOD_STEPS + 4 + DIV45_STEPS + ANGLE_ITERATIONS + 3
                             + DIV_LAT + 1;
   localparam int CAM_LAST = MOD_STEPS + 4 + DIV45_STEPS + ANGLE_ITERATIONS;
   localparam int NF_LAST  = 2 + DIV45_STEPS + ANGLE_ITERATIONS;

   logic                adv;
   logic [PIPE_LAT-1:0] vld_in, vld_ff;

   cam_type  cam_in;
   cam_type  cam_dly_ff [0:CAM_LAST];
   cam_type  cam_sf_ff, cam_pr_ff;

   logic [31:0] rot_abs_in;
   logic        neg_mod_ff [0:MOD_STEPS];
   logic [31:0] r_mod_ff   [0:MOD_STEPS];
   logic [31:0] r_mod_in   [1:MOD_STEPS];

   logic [M0_W-1:0]  m0_in, m0_ff;
   logic [MAG_W-1:0] mag_in, mag_ff;
   fold_type         nf_in;
   fold_type         nf_ff [0:NF_LAST];

   logic [54:0]    p_in, p_ff;
   logic [54:0]    p_rnd;
   logic [Y_W-1:0] y_in, y_ff;

   logic [D45_W-1:0] d45_num_in [0:DIV45_STEPS-1];
   logic [D45_W-1:0] d45_num_ff [0:DIV45_STEPS-1];
   logic [5:0]       d45_rem_in [0:DIV45_STEPS-1];
   logic [5:0]       d45_rem_ff [0:DIV45_STEPS-1];
   logic [D45_W-1:0] d45_q_in   [0:DIV45_STEPS-1];
   logic [D45_W-1:0] d45_q_ff   [0:DIV45_STEPS-1];

   logic signed [CW-1:0] cor_x_ff [0:ANGLE_ITERATIONS-1];
   logic signed [CW-1:0] cor_y_ff [0:ANGLE_ITERATIONS-1];
   logic signed [CW-1:0] cor_z_ff [0:ANGLE_ITERATIONS-1];
   logic signed [CW-1:0] z_init;

   logic signed [CW-1:0] c_wide, s_wide;
   logic signed [31:0]   c_in, s_in, c_sf_ff, s_sf_ff, c_pr_ff, s_pr_ff;

   logic signed [63:0] p_cxc_in, p_cys_in, p_cxs_in, p_cyc_in;
   logic signed [63:0] p_cxc_ff, p_cys_ff, p_cxs_ff, p_cyc_ff;

   logic signed [NUM_W-1:0] num_in [0:5];
   logic signed [NUM_W-1:0] num_ff [0:5];
   logic signed [DEN_W-1:0] dw_in, dh_in, dw8_in, dh8_in;
   logic signed [DEN_W-1:0] dw_ff, dh_ff, dw8_ff, dh8_ff;
   logic                    err_in, err_num_ff;
   logic                    err_dly_ff [0:DIV_LAT-1];

   logic signed [31:0] quo [0:5];
   logic [5:0]         sat;

   logic signed [31:0] r00_ff, r01_ff, r02_ff, r10_ff, r11_ff, r12_ff;
   logic               size_err_ff, sat_ff;

   assign req_stall = vld_ff[PIPE_LAT-1] & rsp_stall;
   assign adv       = ~req_stall;
   assign vld_in    = {vld_ff[PIPE_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // input capture
   always_comb begin
      cam_in.cx  = req_center_x;
      cam_in.cy  = req_center_y;
      cam_in.w   = req_view_width;
      cam_in.h   = req_view_height;
      rot_abs_in = req_rotation_degrees[31] ? (~req_rotation_degrees + 32'd1)
                                             : req_rotation_degrees;
   end

   // |angle| mod 360, one shifted compare-subtract per stage
   always_comb begin
      logic [31:0] dsh;
      for (int k = 1; k <= MOD_STEPS; k++) begin
         dsh         = DEG_360 << (MOD_STEPS - k);
         r_mod_in[k] = (r_mod_ff[k-1] >= dsh) ? (r_mod_ff[k-1] - dsh) : r_mod_ff[k-1];
      end
   end

   // back to a floored modulo in [0, 360)
   always_comb begin
      logic [31:0] m_full;
      m_full = (neg_mod_ff[MOD_STEPS] && r_mod_ff[MOD_STEPS] != 32'd0)
             ? (DEG_360 - r_mod_ff[MOD_STEPS]) : r_mod_ff[MOD_STEPS];
      m0_in  = m_full[M0_W-1:0];
   end

   // fold into [-90, 90], keep magnitude and sign
   always_comb begin
      logic [M0_W-1:0] mg;
      priority if (m0_ff <= DEG_90_M) begin
         mg = m0_ff;
         nf_in.negm = 1'b0;
         nf_in.flip = 1'b0;
      end else if (m0_ff <= DEG_180_M) begin
         mg = DEG_180_M - m0_ff;
         nf_in.negm = m0_ff < DEG_180_M;
         nf_in.flip = 1'b1;
      end else if (m0_ff < DEG_270_M) begin
         mg = m0_ff - DEG_180_M;
         nf_in.negm = 1'b0;
         nf_in.flip = 1'b1;
      end else if (m0_ff == DEG_270_M) begin
         mg = DEG_90_M;
         nf_in.negm = 1'b1;
         nf_in.flip = 1'b0;
      end else begin
         mg = DEG_360_M - m0_ff;
         nf_in.negm = 1'b1;
         nf_in.flip = 1'b0;
      end
      mag_in = mg[MAG_W-1:0];
   end

   // degrees to radians: (mag * 2pi + 90) / (45 * 2^18)
   assign p_in  = 55'(mag_ff) * 55'(TWO_PI_Q29);
   assign p_rnd = p_ff + 55'(DEG_90_M);
   assign y_in  = p_rnd[54:18];

   // divide by 45, eight quotient bits per stage
   always_comb begin
      logic [D45_W-1:0] nm, qq;
      logic [5:0]       rm;
      logic [6:0]       r7;
      for (int s = 0; s < DIV45_STEPS; s++) begin
         if (s == 0) begin
            nm = D45_W'(y_ff);
            rm = '0;
            qq = '0;
         end else begin
            nm = d45_num_ff[s-1];
            rm = d45_rem_ff[s-1];
            qq = d45_q_ff[s-1];
         end
         for (int b = 0; b < D45_BITS; b++) begin
            r7 = {rm, nm[D45_W-1]};
            nm = {nm[D45_W-2:0], 1'b0};
            if (r7 >= DIV45) begin
               rm = 6'(r7 - DIV45);
               qq = {qq[D45_W-2:0], 1'b1};
            end else begin
               rm = r7[5:0];
               qq = {qq[D45_W-2:0], 1'b0};
            end
         end
         d45_num_in[s] = nm;
         d45_rem_in[s] = rm;
         d45_q_in[s]   = qq;
      end
   end

   assign z_init = $signed({1'b0, d45_q_ff[DIV45_STEPS-1][31:0]});

   // cordic rotation, one step per stage
   for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cor
      logic signed [CW-1:0] xa, ya, za, x_in, y_in, z_in, at;

      if (i == 0) begin : g_first
         assign xa = CORDIC_K_Q30;
         assign ya = '0;
         assign za = z_init;
      end else begin : g_next
         assign xa = cor_x_ff[i-1];
         assign ya = cor_y_ff[i-1];
         assign za = cor_z_ff[i-1];
      end

      always_comb begin
         at = $signed({3'b000, ATAN_Q30[i]});
         if (!za[CW-1]) begin
            x_in = xa - (ya >>> i);
            y_in = ya + (xa >>> i);
            z_in = za - at;
         end else begin
            x_in = xa + (ya >>> i);
            y_in = ya - (xa >>> i);
            z_in = za + at;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cor_x_ff[i] <= x_in;
            cor_y_ff[i] <= y_in;
            cor_z_ff[i] <= z_in;
         end
      end
   end

   // undo the fold
   always_comb begin
      c_wide = nf_ff[NF_LAST].flip ? -cor_x_ff[ANGLE_ITERATIONS-1]
                                   : cor_x_ff[ANGLE_ITERATIONS-1];
      s_wide = (nf_ff[NF_LAST].negm ^ nf_ff[NF_LAST].flip) ? -cor_y_ff[ANGLE_ITERATIONS-1]
                                                          : cor_y_ff[ANGLE_ITERATIONS-1];
      c_in   = c_wide[31:0];
      s_in   = s_wide[31:0];
   end

   always_comb begin
      p_cxc_in = 64'(cam_sf_ff.cx) * 64'(c_sf_ff);
      p_cys_in = 64'(cam_sf_ff.cy) * 64'(s_sf_ff);
      p_cxs_in = 64'(cam_sf_ff.cx) * 64'(s_sf_ff);
      p_cyc_in = 64'(cam_sf_ff.cy) * 64'(c_sf_ff);
   end

   // numerators and denominators of the six entries
   always_comb begin
      num_in[0] = NUM_W'(c_pr_ff) <<< 3;
      num_in[1] = NUM_W'(s_pr_ff) <<< 3;
      num_in[2] = -(NUM_W'(p_cxc_ff) + NUM_W'(p_cys_ff));
      num_in[3] = NUM_W'(s_pr_ff) <<< 3;
      num_in[4] = -(NUM_W'(c_pr_ff) <<< 3);
      num_in[5] = NUM_W'(p_cyc_ff) - NUM_W'(p_cxs_ff);
      dw_in     = DEN_W'(cam_pr_ff.w);
      dh_in     = DEN_W'(cam_pr_ff.h);
      dw8_in    = DEN_W'(cam_pr_ff.w) <<< 13;
      dh8_in    = DEN_W'(cam_pr_ff.h) <<< 13;
      err_in    = (cam_pr_ff.w == 32'sd0) || (cam_pr_ff.h == 32'sd0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cam_dly_ff[0] <= cam_in;
         neg_mod_ff[0] <= req_rotation_degrees[31];
         r_mod_ff[0]   <= rot_abs_in;
         for (int k = 1; k <= MOD_STEPS; k++) begin
            neg_mod_ff[k] <= neg_mod_ff[k-1];
            r_mod_ff[k]   <= r_mod_in[k];
         end
         for (int k = 1; k <= CAM_LAST; k++) begin
            cam_dly_ff[k] <= cam_dly_ff[k-1];
         end
         m0_ff    <= m0_in;
         mag_ff   <= mag_in;
         nf_ff[0] <= nf_in;
         for (int k = 1; k <= NF_LAST; k++) begin
            nf_ff[k] <= nf_ff[k-1];
         end
         p_ff <= p_in;
         y_ff <= y_in;
         for (int s = 0; s < DIV45_STEPS; s++) begin
            d45_num_ff[s] <= d45_num_in[s];
            d45_rem_ff[s] <= d45_rem_in[s];
            d45_q_ff[s]   <= d45_q_in[s];
         end
         c_sf_ff   <= c_in;
         s_sf_ff   <= s_in;
         cam_sf_ff <= cam_dly_ff[CAM_LAST];
         p_cxc_ff  <= p_cxc_in;
         p_cys_ff  <= p_cys_in;
         p_cxs_ff  <= p_cxs_in;
         p_cyc_ff  <= p_cyc_in;
         c_pr_ff   <= c_sf_ff;
         s_pr_ff   <= s_sf_ff;
         cam_pr_ff <= cam_sf_ff;
         for (int e = 0; e < 6; e++) begin
            num_ff[e] <= num_in[e];
         end
         dw_ff         <= dw_in;
         dh_ff         <= dh_in;
         dw8_ff        <= dw8_in;
         dh8_ff        <= dh8_in;
         err_num_ff    <= err_in;
         err_dly_ff[0] <= err_num_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            err_dly_ff[k] <= err_dly_ff[k-1];
         end
      end
   end

   vpm_div u_div_r0c0 (.clock(clock), .en(adv), .num(num_ff[0]), .den(dw_ff),
                       .quo(quo[0]), .sat(sat[0]));
   vpm_div u_div_r0c1 (.clock(clock), .en(adv), .num(num_ff[1]), .den(dw_ff),
                       .quo(quo[1]), .sat(sat[1]));
   vpm_div u_div_r0c2 (.clock(clock), .en(adv), .num(num_ff[2]), .den(dw8_ff),
                       .quo(quo[2]), .sat(sat[2]));
   vpm_div u_div_r1c0 (.clock(clock), .en(adv), .num(num_ff[3]), .den(dh_ff),
                       .quo(quo[3]), .sat(sat[3]));
   vpm_div u_div_r1c1 (.clock(clock), .en(adv), .num(num_ff[4]), .den(dh_ff),
                       .quo(quo[4]), .sat(sat[4]));
   vpm_div u_div_r1c2 (.clock(clock), .en(adv), .num(num_ff[5]), .den(dh8_ff),
                       .quo(quo[5]), .sat(sat[5]));

   // output register, zero size overrides the entries
   always_ff @(posedge clock) begin
      if (adv) begin
         r00_ff      <= err_dly_ff[DIV_LAT-1] ? 32'sd0 : quo[0];
         r01_ff      <= err_dly_ff[DIV_LAT-1] ? 32'sd0 : quo[1];
         r02_ff      <= err_dly_ff[DIV_LAT-1] ? 32'sd0 : quo[2];
         r10_ff      <= err_dly_ff[DIV_LAT-1] ? 32'sd0 : quo[3];
         r11_ff      <= err_dly_ff[DIV_LAT-1] ? 32'sd0 : quo[4];
         r12_ff      <= err_dly_ff[DIV_LAT-1] ? 32'sd0 : quo[5];
         size_err_ff <= err_dly_ff[DIV_LAT-1];
         sat_ff      <= ~err_dly_ff[DIV_LAT-1] & (|sat);
      end
   end

   assign rsp_valid      = vld_ff[PIPE_LAT-1];
   assign rsp_row0_col0  = r00_ff;
   assign rsp_row0_col1  = r01_ff;
   assign rsp_row0_col2  = r02_ff;
   assign rsp_row1_col0  = r10_ff;
   assign rsp_row1_col1  = r11_ff;
   assign rsp_row1_col2  = r12_ff;
   assign rsp_size_error = size_err_ff;
   assign rsp_saturated  = sat_ff;

endmodule

>>> bench/view_projection_matrix_2d_test.sv
// testbench for the 2d view-projection matrix block with a software matrix predictor
module view_projection_matrix_2d_test
   import vpm_pkg::*;
();

   localparam int RANDOM_CAMERAS = 450;
   localparam int QUIET_TAIL     = 50;
   localparam int IDLE_LIMIT     = 3000;
   localparam int DRAIN_CYCLES   = 120;

   localparam longint DEG360 = 64'sd23592960;
   localparam longint DEG180 = 64'sd11796480;
   localparam longint DEG90  = 64'sd5898240;
   localparam longint TWO_PI = 64'sd3373259426;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] w;
      logic signed [31:0] h;
      logic signed [31:0] rot;
   } camera_type;

   typedef struct packed {
      logic [31:0] m00;
      logic [31:0] m01;
      logic [31:0] m02;
      logic [31:0] m10;
      logic [31:0] m11;
      logic [31:0] m12;
      logic        size_error;
      logic        saturated;
   } matrix_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_center_x;
   logic signed [31:0] req_center_y;
   logic signed [31:0] req_view_width;
   logic signed [31:0] req_view_height;
   logic signed [31:0] req_rotation_degrees;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_row0_col0;
   logic signed [31:0] rsp_row0_col1;
   logic signed [31:0] rsp_row0_col2;
   logic signed [31:0] rsp_row1_col0;
   logic signed [31:0] rsp_row1_col1;
   logic signed [31:0] rsp_row1_col2;
   logic               rsp_size_error;
   logic               rsp_saturated;

   camera_type camera_q[$];
   matrix_type matrix_q[$];
   int         mismatches = 0;
   int         req_gap = 0;
   int         rsp_gap = 0;
   int         idle_cycles = 0;

   view_projection_matrix_2d dut (.*);

   // cosine and sine in q2.30 of an angle in q16.16 degrees
   function automatic void rotate_angle(input longint deg, output longint cosv,
                                        output longint sinv);
      longint m, z, x, y, dx, dy;
      longint unsigned mag;
      bit flip, neg;
      m = deg % DEG360;
      flip = 0;
      if (m < 0) m += DEG360;
      if (m > DEG180) m -= DEG360;
      if (m > DEG90) begin
         m -= DEG180;
         flip = 1;
      end else if (m < -DEG90) begin
         m += DEG180;
         flip = 1;
      end
      neg = m < 0;
      mag = neg ? -m : m;
      z = (mag * TWO_PI + DEG90) / DEG180;
      x = CORDIC_K_Q30;
      y = 0;
      for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(ATAN_Q30[i]);
         end else begin
            x += dx;
            y -= dy;
            z += longint'(ATAN_Q30[i]);
         end
      end
      if (neg) y = -y;
      if (flip) begin
         x = -x;
         y = -y;
      end
      cosv = x;
      sinv = y;
   endfunction

   // quotient rounded to nearest, ties away from zero, then clipped to 32 bits
   function automatic logic [31:0] div_clip(longint n, longint d, inout bit sat);
      longint unsigned un, ud, q;
      longint v;
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = (un + ud / 2) / ud;
      v = ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
      if (v > 64'sd2147483647) begin
         v = 64'sd2147483647;
         sat = 1;
      end else if (v < -64'sd2147483648) begin
         v = -64'sd2147483648;
         sat = 1;
      end
      return v[31:0];
   endfunction

   function automatic matrix_type project_camera(camera_type cam);
      matrix_type r;
      longint cx, cy, w, h, c, s;
      bit sat;
      cx = cam.cx;
      cy = cam.cy;
      w = cam.w;
      h = cam.h;
      sat = 0;
      r = '0;
      if (w == 0 || h == 0) begin
         r.size_error = 1;
         return r;
      end
      rotate_angle(cam.rot, c, s);
      r.m00 = div_clip(8 * c, w, sat);
      r.m01 = div_clip(8 * s, w, sat);
      r.m02 = div_clip(-(cx * c + cy * s), w * 8192, sat);
      r.m10 = div_clip(8 * s, h, sat);
      r.m11 = div_clip(-8 * c, h, sat);
      r.m12 = div_clip(-(cx * s - cy * c), h * 8192, sat);
      r.saturated = sat;
      return r;
   endfunction

   function automatic camera_type make_camera(int cx, int cy, int w, int h, int rot);
      camera_type cam;
      cam.cx = cx;
      cam.cy = cy;
      cam.w = w;
      cam.h = h;
      cam.rot = rot;
      return cam;
   endfunction

   function automatic logic signed [31:0] random_size();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(3) == 0 ? 32'sd0 : $urandom_range(255);
         2: return -$signed({1'b0, 31'($urandom_range(32'h7fffff))});
         default: return $urandom_range(32'h7fffff, 32'h400);
      endcase
   endfunction

   function automatic logic signed [31:0] random_angle();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed(32'($urandom_range(8)) * 32'sd2949120) - 32'sd11796480;
         default: return $signed(32'($urandom_range(47185920))) - 32'sd23592960;
      endcase
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            matrix_q.push_back(project_camera(camera_q.pop_front()));
         if (!(req_valid && req_stall)) begin
            if (req_gap > 0)
               req_gap--;
            else if (camera_q.size() > QUIET_TAIL && $urandom_range(7) == 0)
               req_gap = $urandom_range(10, 1);
            if (req_gap == 0 && camera_q.size() > 0) begin
               req_valid <= 1;
               req_center_x <= camera_q[0].cx;
               req_center_y <= camera_q[0].cy;
               req_view_width <= camera_q[0].w;
               req_view_height <= camera_q[0].h;
               req_rotation_degrees <= camera_q[0].rot;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (matrix_q.size() == 0) begin
               $error("result with no request outstanding");
               mismatches++;
            end else begin
               matrix_type e;
               e = matrix_q.pop_front();
               check_field("row0_col0", e.m00, rsp_row0_col0);
               check_field("row0_col1", e.m01, rsp_row0_col1);
               check_field("row0_col2", e.m02, rsp_row0_col2);
               check_field("row1_col0", e.m10, rsp_row1_col0);
               check_field("row1_col1", e.m11, rsp_row1_col1);
               check_field("row1_col2", e.m12, rsp_row1_col2);
               check_field("size_error", e.size_error, rsp_size_error);
               check_field("saturated", e.saturated, rsp_saturated);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
         end else if (camera_q.size() > QUIET_TAIL && $urandom_range(7) == 0) begin
            rsp_gap = $urandom_range(10, 1) - 1;
         end
         rsp_stall <= (rsp_gap > 0) || (camera_q.size() > QUIET_TAIL && rsp_gap == 0
                      && $urandom_range(15) == 0);
      end
   end

   // watchdog on cycles where work is pending but nothing moves
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (camera_q.size() == 0 && matrix_q.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_center_x = 0;
      req_center_y = 0;
      req_view_width = 0;
      req_view_height = 0;
      req_rotation_degrees = 0;
      rsp_stall = 0;

      // zero sizes, extremes, folding edges, saturation, mirrored axes
      camera_q.push_back(make_camera(32'h10000, 32'h20000, 0, 32'h10000, 0));
      camera_q.push_back(make_camera(32'h10000, 32'h20000, 32'h10000, 0, 32'h5a0000));
      camera_q.push_back(make_camera(-1, -1, 0, 0, -1));
      camera_q.push_back(make_camera(0, 0, 32'h20000, 32'h20000, 0));
      camera_q.push_back(make_camera(32'h40000, -32'h30000, 32'h100000, 32'hc0000,
                                     32'h5a0000));
      camera_q.push_back(make_camera(32'h40000, 32'h30000, 32'h100000, 32'hc0000,
                                     32'hb40000));
      camera_q.push_back(make_camera(32'h40000, 32'h30000, 32'h100000, 32'hc0000,
                                     -32'hb40000));
      camera_q.push_back(make_camera(32'h40000, 32'h30000, 32'h100000, 32'hc0000,
                                     -32'h5a0000));
      camera_q.push_back(make_camera(1, 1, 32'h100000, 32'hc0000, 32'h5a0001));
      camera_q.push_back(make_camera(1, 1, 32'h100000, 32'hc0000, -32'h5a0001));
      camera_q.push_back(make_camera(1, 1, 32'h100000, 32'hc0000, 32'h10e0000));
      camera_q.push_back(make_camera(1, 1, 32'h100000, 32'hc0000, 32'h1680000));
      camera_q.push_back(make_camera(5, 7, 32'h100000, 32'hc0000, 32'h7fffffff));
      camera_q.push_back(make_camera(5, 7, 32'h100000, 32'hc0000, 32'h80000000));
      camera_q.push_back(make_camera(32'h7fffffff, 32'h80000000, 1, -1, 32'h2d0000));
      camera_q.push_back(make_camera(32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                     32'h80000000, 32'h1e0000));
      camera_q.push_back(make_camera(32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                     32'h7fffffff, 32'h80000000));
      camera_q.push_back(make_camera(32'h7fffffff, -32'h10000, 32'h100, 32'h100,
                                     32'h2d0000));
      camera_q.push_back(make_camera(-32'h280000, 32'h190000, -32'h140000, -32'hf0000,
                                     32'h3c0000));
      camera_q.push_back(make_camera(32'hffffffff, 32'hffffffff, 32'hffffffff,
                                     32'hffffffff, 32'hffffffff));
      for (int i = 0; i < RANDOM_CAMERAS; i++) begin
         camera_type cam;
         if ($urandom_range(4) == 0)
            cam = make_camera($urandom, $urandom, $urandom, $urandom, $urandom);
         else
            cam = make_camera($signed(32'($urandom_range(32'h1000000))) - 32'sh800000,
                              $urandom_range(1) ? $urandom
                                 : $signed(32'($urandom_range(32'h1000000))) - 32'sh800000,
                              random_size(), random_size(), random_angle());
         camera_q.push_back(cam);
      end

      repeat (8) @(posedge clock);
      reset <= 0;
      while (camera_q.size() > 0 || matrix_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
